### hdl/counting_semaphore_fifo_waiters_assert.svh
// Assertion macros used by the semaphore RTL.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CSFW_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CSFW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/csfw_pkg.sv
`default_nettype none

package csfw_pkg;

   localparam int TASK_W  = 5;
   localparam int COUNT_W = 17;
   localparam int INIT_W  = 16;

   localparam logic MODE_WAIT = 1'b0;
   localparam logic MODE_POST = 1'b1;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_FULL  = 2'd1,
      FAULT_EMPTY = 2'd2,
      FAULT_SAT   = 2'd3
   } fault_type;

   // Commands from the semaphore core to the wait queue.
   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pop;
      logic [TASK_W-1:0] push_task;
   } qctl_type;

   // Status of the wait queue seen by the core.
   typedef struct packed {
      logic              full;
      logic              empty;
      logic [TASK_W-1:0] head_task;
   } qstat_type;

endpackage

`default_nettype wire

### hdl/csfw_queue.sv
`default_nettype none

module csfw_queue
   import csfw_pkg::*;
#(
   parameter int MAX_WAITERS = 32
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire qctl_type  qctl,
   output qstat_type      qstat
);

   localparam int PTR_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int FILL_W = $clog2(MAX_WAITERS + 1);

   logic [TASK_W-1:0] mem_ff [MAX_WAITERS];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TASK_W-1:0] head_task_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(MAX_WAITERS - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (qctl.clear) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (qctl.push) begin
         tail_in = ptr_next(tail_ff);
         fill_in = fill_ff + 1'b1;
      end else if (qctl.pop) begin
         head_in = ptr_next(head_ff);
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // The read port always fetches the entry at the next head, so the task to
   // wake is ready in a register. A push into the slot being fetched is
   // forwarded, which covers a push into an empty queue.
   always_ff @(posedge clock) begin
      if (qctl.push && !qctl.clear) begin
         mem_ff[tail_ff] <= qctl.push_task;
      end
      if (qctl.push && !qctl.clear && (tail_ff == head_in)) begin
         head_task_ff <= qctl.push_task;
      end else begin
         head_task_ff <= mem_ff[head_in];
      end
   end

   assign qstat.full      = (fill_ff == FILL_W'(MAX_WAITERS));
   assign qstat.empty     = (fill_ff == '0);
   assign qstat.head_task = head_task_ff;

endmodule

`default_nettype wire

### hdl/counting_semaphore_fifo_waiters.sv
`default_nettype none

// Counting semaphore with a first-in first-out queue of up to MAX_WAITERS
// blocked task numbers. Each request beat (tuser = 0 wait, 1 post) yields one
// response beat; the block takes one beat per clock while rsp_tready is not held low.
// A request passes the input register, then the result register, before its
// response is presented; a response that is not taken holds both registers.
// The queue is a memory with one write port and one registered read port that
// always holds the task at the next head. Writing csr_wdata with csr_wen
// reloads the count and empties the queue at once; do so only while no
// request is in flight. Faults (queue full on wait, queue empty on post,
// count at 65535 on post) leave the state unchanged.
module counting_semaphore_fifo_waiters
   import csfw_pkg::*;
#(
   parameter int MAX_WAITERS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wen,
   input  wire logic [INIT_W-1:0] csr_wdata,    // initial_count
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,    // [4:0] task_id, [7:5] zero
   input  wire logic              req_tuser,    // [0] mode
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata     // [0] caller_blocked, [1] woken_valid,
                                                // [6:2] woken_task, [8:7] fault,
                                                // [25:9] count_now, [31:26] zero
);

   localparam logic signed [COUNT_W-1:0] COUNT_TOP = 17'sd65535;

   logic              in_valid_ff, in_valid_in;
   logic              in_mode_ff;
   logic [TASK_W-1:0] in_task_ff;

   logic              out_valid_ff, out_valid_in;
   logic              out_blocked_ff;
   logic              out_woken_ff;
   logic [TASK_W-1:0] out_task_ff;
   fault_type         out_fault_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic signed [COUNT_W-1:0] count_ff, count_in;

   logic              advance;
   logic              process;
   logic              count_neg;
   logic              count_le0;
   logic              res_blocked;
   logic              res_woken;
   fault_type         res_fault;

   qctl_type          qctl;
   qstat_type         qstat;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign process    = in_valid_ff && advance;

   assign count_neg  = count_ff[COUNT_W-1];
   assign count_le0  = count_neg || (count_ff == '0);

   always_comb begin
      res_blocked = 1'b0;
      res_woken   = 1'b0;
      res_fault   = FAULT_NONE;
      unique case (in_mode_ff)
         MODE_WAIT: begin
            if (count_le0) begin
               if (qstat.full) begin
                  res_fault = FAULT_FULL;
               end else begin
                  res_blocked = 1'b1;
               end
            end
         end
         MODE_POST: begin
            if (count_ff >= COUNT_TOP) begin
               res_fault = FAULT_SAT;
            end else if (count_neg) begin
               if (qstat.empty) begin
                  res_fault = FAULT_EMPTY;
               end else begin
                  res_woken = 1'b1;
               end
            end
         end
         default: begin
            res_fault = FAULT_NONE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (csr_wen) begin
         count_in = signed'({1'b0, csr_wdata});
      end else if (process && (res_fault == FAULT_NONE)) begin
         if (in_mode_ff == MODE_WAIT) begin
            count_in = count_ff - 17'sd1;
         end else begin
            count_in = count_ff + 17'sd1;
         end
      end
   end

   assign qctl.clear     = csr_wen;
   assign qctl.push      = process && res_blocked;
   assign qctl.pop       = process && res_woken;
   assign qctl.push_task = in_task_ff;

   csfw_queue #(
      .MAX_WAITERS (MAX_WAITERS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .qctl  (qctl),
      .qstat (qstat)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser;
         in_task_ff <= req_tdata[TASK_W-1:0];
      end
      if (process) begin
         out_blocked_ff <= res_blocked;
         out_woken_ff   <= res_woken;
         out_task_ff    <= res_woken ? qstat.head_task : '0;
         out_fault_ff   <= res_fault;
         out_count_ff   <= count_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_count_ff, out_fault_ff, out_task_ff,
                        out_woken_ff, out_blocked_ff};

   `include "counting_semaphore_fifo_waiters_assert.svh"

   // A negative count always means tasks are queued, and only then.
   `CSFW_ASSERT_HOLDS(a_count_matches_queue, clock, reset,
      count_neg == !qstat.empty,
      "semaphore count sign disagrees with wait queue occupancy")
   // A faulting operation leaves the count untouched.
   `CSFW_ASSERT_NEXT(a_fault_keeps_count, clock, reset,
      process && (res_fault != FAULT_NONE) && !csr_wen, $stable(count_ff),
      "faulting operation changed the count")
   // A blocked caller is only reported with a negative count.
   `CSFW_ASSERT_HOLDS(a_blocked_negative, clock, reset,
      !(out_valid_ff && out_blocked_ff) || out_count_ff[COUNT_W-1],
      "blocked caller reported with non-negative count")

endmodule

`default_nettype wire
